// ===== design/afp_pkg.sv =====
// shared types and constants for the av sync frame pacer
package afp_pkg;

  localparam int unsigned WINDOW = 10;
  localparam int unsigned TS_W = 32;
  localparam int unsigned CFG_W = 16;
  localparam int unsigned IVL_W = 16;
  localparam int unsigned SUM_W = 20;
  localparam int unsigned POS_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned FILL_W = $clog2(WINDOW + 1);
  localparam int unsigned LEAD_SHIFT = 3;

  // sum / WINDOW as (sum * DIV_RECIP) >> DIV_SHIFT, exact for any sum below 2**SUM_W
  localparam int unsigned DIV_SHIFT = 24;
  localparam int unsigned RECIP_W = DIV_SHIFT + 1;
  localparam logic [RECIP_W-1:0] DIV_RECIP = RECIP_W'((64'd1 << DIV_SHIFT) / WINDOW + 64'd1);

  localparam logic [CFG_W-1:0] RST_MAX_AUDIO_IDLE = 16'd500;
  localparam logic [CFG_W-1:0] RST_MAX_INTERVAL = 16'd1000;
  localparam logic [CFG_W-1:0] RST_MAX_WAIT = 16'd1000;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BACKWARDS = 2'd1,
    ST_NOT_INCR  = 2'd2
  } afp_status_e;

  typedef enum logic [1:0] {
    CFG_MAX_AUDIO_IDLE = 2'd0,
    CFG_MAX_INTERVAL   = 2'd1,
    CFG_MAX_WAIT       = 2'd2
  } afp_cfg_idx_e;

  typedef struct packed {
    logic [TS_W-1:0] video_ts;
    logic [TS_W-1:0] audio_ts;
    logic [TS_W-1:0] audio_idle;
    logic [TS_W-1:0] clock_time;
    logic [TS_W-1:0] now_ms;
  } afp_in_t;

  typedef struct packed {
    logic [CFG_W-1:0] wait_ms;
    logic [1:0]       status;
  } afp_out_t;

  // frame held between the state update and the wait computation
  typedef struct packed {
    logic            valid;
    afp_status_e     status;
    logic [TS_W-1:0] lead;
  } afp_stage_t;

  // ring state as seen by the wait computation
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             full;
  } afp_ring_t;

endpackage

// ===== design/afp_ring.sv =====
// interval window: ring memory with running sum and fill count
module afp_ring
  import afp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rec_i,
  input  logic [IVL_W-1:0] interval_i,
  output afp_ring_t        ring_o
);

  logic [IVL_W-1:0]  mem [WINDOW];
  logic [IVL_W-1:0]  old_q;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic              full;

  assign full = (fill_q == FILL_W'(WINDOW));

  always_comb begin
    pos_d  = pos_q;
    fill_d = fill_q;
    sum_d  = sum_q;
    if (rec_i) begin
      pos_d  = (pos_q == POS_W'(WINDOW - 1)) ? '0 : pos_q + 1'b1;
      fill_d = full ? fill_q : fill_q + 1'b1;
      sum_d  = sum_q - (full ? SUM_W'(old_q) : '0) + SUM_W'(interval_i);
    end
  end

  // read runs one entry ahead: old_q always holds the entry at pos_q,
  // and a write never hits the address read in the same cycle
  always_ff @(posedge clk_i) begin
    if (rec_i) begin
      mem[pos_q] <= interval_i;
    end
    old_q <= mem[pos_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      fill_q <= '0;
      sum_q  <= '0;
    end else begin
      pos_q  <= pos_d;
      fill_q <= fill_d;
      sum_q  <= sum_d;
    end
  end

  assign ring_o.sum  = sum_q;
  assign ring_o.full = full;

endmodule

// ===== design/afp_wait.sv =====
// wait computation from lead and, once the window is full, window mean; clamp, output register
module afp_wait
  import afp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  afp_stage_t       stage_i,
  input  afp_ring_t        ring_i,
  input  logic [CFG_W-1:0] max_wait_i,
  output logic             stage_ready_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output afp_out_t         out_data_o
);

  localparam int unsigned WAIT_W = TS_W + 1;
  localparam int unsigned PROD_W = SUM_W + RECIP_W;

  logic [PROD_W-1:0]        prod;
  logic [SUM_W-1:0]         mean;
  logic [WAIT_W-1:0]        wait_raw;
  logic [CFG_W-1:0]         wait_clamped;
  logic                     out_valid_q;
  afp_out_t                 out_q;

  assign prod = PROD_W'(ring_i.sum) * PROD_W'(DIV_RECIP);
  assign mean = prod[DIV_SHIFT +: SUM_W];

  always_comb begin
    if (stage_i.status != ST_OK) begin
      wait_raw = '0;
    end else if (ring_i.full) begin
      wait_raw = (stage_i.lead == '0) ? '0
               : WAIT_W'(mean) + WAIT_W'(stage_i.lead >> LEAD_SHIFT);
    end else begin
      wait_raw = WAIT_W'(stage_i.lead);
    end
    wait_clamped = (wait_raw > WAIT_W'(max_wait_i)) ? max_wait_i : wait_raw[CFG_W-1:0];
  end

  assign stage_ready_o = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (stage_ready_o) begin
      out_valid_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_ready_o && stage_i.valid) begin
      out_q.wait_ms <= wait_clamped;
      out_q.status  <= stage_i.status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== design/av_sync_frame_pacer_unit.sv =====
// top level of the av sync frame pacer
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid_i/in_stall_o | in_data_i (afp_in_t)
//  out     | output    | out_valid_o/out_stall_i | out_data_o (afp_out_t)
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// one frame per cycle while the output is not stalled; a result passes the middle stage, then the output register
// the ring read runs one entry ahead of the write pointer, so the
//   read-modify-write of the sum closes in the accept cycle
// reset clears the pointers, fill count, sum and history; the ring needs no clearing
// a stalled output holds its result while one more frame waits in the middle stage
module av_sync_frame_pacer_unit
  import afp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  afp_in_t    in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output afp_out_t   out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  logic [CFG_W-1:0] max_audio_idle_q, max_interval_q, max_wait_q;
  logic             started_q;
  logic [TS_W-1:0]  last_now_q, last_vts_q;
  afp_stage_t       stage_q;
  afp_ring_t        ring;
  logic             stage_ready;
  logic             accept;
  logic [TS_W-1:0]  sync_ref, lead, interval;
  logic             err_back, err_incr, frame_ok, rec;
  afp_status_e      status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_audio_idle_q <= RST_MAX_AUDIO_IDLE;
      max_interval_q   <= RST_MAX_INTERVAL;
      max_wait_q       <= RST_MAX_WAIT;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MAX_AUDIO_IDLE: max_audio_idle_q <= cfg_data_i;
        CFG_MAX_INTERVAL:   max_interval_q   <= cfg_data_i;
        CFG_MAX_WAIT:       max_wait_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = stage_q.valid && !stage_ready;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    sync_ref = (in_data_i.audio_idle < TS_W'(max_audio_idle_q))
             ? in_data_i.audio_ts : in_data_i.clock_time;
    lead     = (in_data_i.video_ts > sync_ref) ? in_data_i.video_ts - sync_ref : '0;
    err_back = started_q && (in_data_i.now_ms < last_now_q);
    err_incr = started_q && !err_back && (in_data_i.video_ts <= last_vts_q);
    frame_ok = !err_back && !err_incr;
    interval = in_data_i.video_ts - last_vts_q;
    rec      = accept && frame_ok && started_q && (interval < TS_W'(max_interval_q));
    priority if (err_back) begin
      status = ST_BACKWARDS;
    end else if (err_incr) begin
      status = ST_NOT_INCR;
    end else begin
      status = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q  <= 1'b0;
      last_now_q <= '0;
      last_vts_q <= '0;
    end else if (accept && frame_ok) begin
      started_q  <= 1'b1;
      last_now_q <= in_data_i.now_ms;
      last_vts_q <= in_data_i.video_ts;
    end
  end

  // the ring only moves when a frame enters this stage, so while a frame
  // sits here the ring state is exactly the one it left behind
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else begin
      if (!stage_q.valid || stage_ready) begin
        stage_q.valid <= accept;
      end
      if (accept) begin
        stage_q.status <= status;
        stage_q.lead   <= lead;
      end
    end
  end

  afp_ring u_ring (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rec_i      (rec),
    .interval_i (interval[IVL_W-1:0]),
    .ring_o     (ring)
  );

  afp_wait u_wait (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .stage_i       (stage_q),
    .ring_i        (ring),
    .max_wait_i    (max_wait_q),
    .stage_ready_o (stage_ready),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_o    (out_data_o)
  );

  a_err_zero_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != ST_OK) |-> out_data_o.wait_ms == '0)
    else $error("error transaction carries a nonzero wait");

  a_wait_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.wait_ms <= max_wait_q)
    else $error("wait above the configured maximum");

  a_err_keeps_history: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !frame_ok |=> $stable(last_now_q) && $stable(last_vts_q))
    else $error("rejected frame changed the timestamp history");

  a_first_frame_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !started_q |-> frame_ok && !rec)
    else $error("first frame rejected or recorded an interval");

endmodule
